@@ rtl/core/ptt_pkg.sv @@
// Package with the types, constants and codes of the property tween table.
`default_nettype none
package ptt_pkg;
    localparam int SLOTS = 8;
    localparam int TARGET_BITS = 8;
    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W = $clog2(SLOTS + 1);

    localparam logic [2:0] KIND_ONCE = 3'd0;
    localparam logic [2:0] KIND_REPEAT = 3'd1;
    localparam logic [2:0] KIND_TICK = 3'd2;
    localparam logic [2:0] KIND_FINISH = 3'd3;
    localparam logic [2:0] KIND_DETACH = 3'd4;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_BAD_DUR = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;
    localparam logic [1:0] ST_SHORT = 2'd3;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] target;
        logic [3:0] property_req;
        logic is_color;
        logic signed [31:0] current_value;
        logic signed [31:0] start_value;
        logic signed [31:0] end_value;
        logic [15:0] duration;
    } t_in_word;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] out_target;
        logic [3:0] out_property;
        logic signed [31:0] out_value;
        logic last;
    } t_out_word;

    typedef enum logic [3:0] {
        S_IDLE, S_SEARCH, S_WRITE, S_TICK_LOAD, S_TICK_DIV, S_TICK_EMIT,
        S_TICK_SWEEP, S_FINISH, S_DETACH
    } t_state;
endpackage
`default_nettype wire

@@ rtl/core/property_tween_table_unit.sv @@
// Top level of the property tween table with a shared serial divider.
`default_nettype none
// Usage: pulse start with a command word on i_in while busy is low.
// Results appear one at a time on o_out, each for a single cycle with
// o_valid high; the receiver cannot stall, and o_out.last marks the final
// result of a command. A start command searches the table one entry a cycle
// and then emits its status word. A tick visits every entry in order: a
// value that needs no divide is taken as it is, a word value takes one
// 48-bit restoring divide of one quotient bit per cycle and a color value
// four such divides. After the last entry a compaction sweep follows.
// Finish emits one end value per cycle in reverse order; detach compacts
// the table. Commands of an unknown kind are accepted and ignored, and the
// block stays idle. Reset empties the table at once; entry contents need
// no clearing since only entries below the count are read.
module property_tween_table_unit (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire ptt_pkg::t_in_word i_in,
    output logic                  o_valid,
    output ptt_pkg::t_out_word    o_out
);
    import ptt_pkg::*;

    logic [TARGET_BITS-1:0] r_tg [SLOTS];
    logic [3:0]  r_pr [SLOTS];
    logic        r_col [SLOTS];
    logic        r_rep [SLOTS];
    logic [31:0] r_a [SLOTS];
    logic [31:0] r_z [SLOTS];
    logic [15:0] r_pos [SLOTS];
    logic [15:0] r_len [SLOTS];

    t_state r_state, n_state;
    t_in_word r_cmd;
    logic [CNT_W-1:0] r_count, r_i, r_w;
    logic r_found;
    logic [IDX_W-1:0] r_idx;
    logic [1:0] r_byte;
    logic [47:0] r_num;
    logic r_neg;
    logic [16:0] r_rem;
    logic [5:0] r_bit;
    logic [16:0] r_c;
    logic [31:0] r_acc;
    logic [1:0] r_mode;
    logic [31:0] r_fixed;

    localparam logic [1:0] M_FIXED = 2'd0;
    localparam logic [1:0] M_WORD = 2'd1;
    localparam logic [1:0] M_COLOR = 2'd2;

    logic [IDX_W-1:0] i_ix, w_ix;
    assign i_ix = r_i[IDX_W-1:0];
    assign w_ix = r_w[IDX_W-1:0];

    logic [TARGET_BITS-1:0] cmd_tg;
    assign cmd_tg = r_cmd.target[TARGET_BITS-1:0];

    logic [15:0] pos_inc;
    logic [16:0] cc, pp;
    logic [17:0] pf;
    always_comb begin
        pos_inc = r_pos[i_ix] + 16'd1;
        cc = {1'b0, r_len[i_ix]};
        pf = {2'b0, pos_inc};
        if (r_rep[i_ix]) begin
            cc = {2'b0, r_len[i_ix][15:1]};
            if (cc != 17'd0 && {1'b0, pos_inc} > cc) begin
                pf = {cc, 1'b0} - {2'b0, pos_inc};
            end
        end
        pp = pf[16:0];
    end

    logic [7:0] ab, zb;
    logic signed [9:0] db;
    always_comb begin
        ab = r_a[i_ix][8*r_byte +: 8];
        zb = r_z[i_ix][8*r_byte +: 8];
        db = $signed({2'b0, zb}) - $signed({2'b0, ab});
    end

    logic signed [33:0] dw;
    assign dw = $signed({r_z[i_ix][31], r_z[i_ix][31], r_z[i_ix]})
        - $signed({r_a[i_ix][31], r_a[i_ix][31], r_a[i_ix]});

    logic [33:0] dmag;
    logic [9:0] bmag;
    assign dmag = dw[33] ? 34'(-dw) : 34'(dw);
    assign bmag = db[9] ? 10'(-db) : 10'(db);

    logic [17:0] trial;
    assign trial = {r_rem, r_num[47]} - {1'b0, r_c};

    logic [31:0] q32;
    assign q32 = r_neg ? 32'(-r_num[31:0]) : r_num[31:0];

    logic [1:0] byte_next;
    logic [7:0] ab_next, zb_next;
    logic signed [9:0] db_next;
    logic [9:0] bmag_next;
    logic [15:0] pp_hold;
    always_comb begin
        byte_next = r_byte + 2'd1;
        ab_next = r_a[i_ix][8*byte_next +: 8];
        zb_next = r_z[i_ix][8*byte_next +: 8];
        db_next = $signed({2'b0, zb_next}) - $signed({2'b0, ab_next});
        bmag_next = db_next[9] ? 10'(-db_next) : 10'(db_next);
        pp_hold = pp[15:0];
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    case (i_in.kind)
                        KIND_ONCE, KIND_REPEAT: n_state = S_SEARCH;
                        KIND_TICK: n_state = S_TICK_LOAD;
                        KIND_FINISH: n_state = S_FINISH;
                        KIND_DETACH: n_state = S_DETACH;
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_SEARCH: begin
                if (r_found || r_i == r_count) begin
                    n_state = S_WRITE;
                end
            end
            S_WRITE: n_state = S_IDLE;
            S_TICK_LOAD: begin
                if (r_i == r_count) begin
                    n_state = S_TICK_SWEEP;
                end else begin
                    n_state = S_TICK_DIV;
                end
            end
            S_TICK_DIV: begin
                if (r_mode == M_FIXED) begin
                    n_state = S_TICK_EMIT;
                end else if (r_bit == 6'd0) begin
                    if (r_mode == M_COLOR && r_byte != 2'd3) begin
                        n_state = S_TICK_DIV;
                    end else begin
                        n_state = S_TICK_EMIT;
                    end
                end
            end
            S_TICK_EMIT: n_state = S_TICK_LOAD;
            S_TICK_SWEEP: begin
                if (r_i == r_count) begin
                    n_state = S_IDLE;
                end
            end
            S_FINISH: begin
                if (r_count == '0) begin
                    n_state = S_IDLE;
                end
            end
            S_DETACH: begin
                if (r_i == r_count) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        busy = (r_state != S_IDLE);
    end

    logic [1:0] start_status;
    always_comb begin
        start_status = ST_OK;
        if (r_cmd.kind == KIND_ONCE && r_cmd.duration == 16'd0) begin
            start_status = ST_BAD_DUR;
        end else if (r_cmd.kind == KIND_REPEAT && r_cmd.duration < 16'd2) begin
            start_status = ST_SHORT;
        end else if (!r_found && r_count == CNT_W'(SLOTS)) begin
            start_status = ST_FULL;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            o_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    r_cmd <= i_in;
                    r_i <= '0;
                    r_w <= '0;
                    r_found <= 1'b0;
                    r_byte <= '0;
                end
                S_SEARCH: begin
                    if (!r_found && r_i != r_count) begin
                        if (r_tg[i_ix] == cmd_tg && r_pr[i_ix] == r_cmd.property_req) begin
                            r_found <= 1'b1;
                            r_idx <= i_ix;
                        end else begin
                            r_i <= r_i + 1'b1;
                        end
                    end
                end
                S_WRITE: begin
                    o_valid <= 1'b1;
                    o_out.status <= start_status;
                    o_out.out_target <= 8'(cmd_tg);
                    o_out.out_property <= r_cmd.property_req;
                    o_out.out_value <= '0;
                    o_out.last <= 1'b1;
                    if (start_status == ST_OK) begin
                        if (!r_found) begin
                            r_tg[r_count[IDX_W-1:0]] <= cmd_tg;
                            r_pr[r_count[IDX_W-1:0]] <= r_cmd.property_req;
                            r_count <= r_count + 1'b1;
                        end
                        for (int k = 0; k < SLOTS; k++) begin
                            if ((r_found && r_idx == IDX_W'(k))
                                || (!r_found && r_count == CNT_W'(k))) begin
                                r_col[k] <= r_cmd.is_color;
                                r_rep[k] <= (r_cmd.kind == KIND_REPEAT);
                                r_a[k] <= (r_cmd.kind == KIND_REPEAT && !r_found)
                                    ? r_cmd.start_value : r_cmd.current_value;
                                r_z[k] <= r_cmd.end_value;
                                r_pos[k] <= '0;
                                r_len[k] <= r_cmd.duration;
                            end
                        end
                    end
                end
                S_TICK_LOAD: begin
                    if (r_i != r_count) begin
                        r_c <= cc;
                        r_byte <= '0;
                        r_bit <= 6'd47;
                        r_rem <= '0;
                        r_acc <= '0;
                        if (pf[17] || pp == 17'd0) begin
                            r_mode <= M_FIXED;
                            r_fixed <= r_a[i_ix];
                        end else if (pp >= cc) begin
                            r_mode <= M_FIXED;
                            r_fixed <= r_z[i_ix];
                        end else if (r_a[i_ix] == r_z[i_ix]) begin
                            r_mode <= M_FIXED;
                            r_fixed <= r_a[i_ix];
                        end else if (r_col[i_ix]) begin
                            r_mode <= M_COLOR;
                            r_num <= 48'(bmag * pp[15:0]);
                            r_neg <= db[9];
                        end else begin
                            r_mode <= M_WORD;
                            r_num <= 48'(dmag * pp[15:0]);
                            r_neg <= dw[33];
                        end
                    end else begin
                        r_i <= '0;
                        r_w <= '0;
                    end
                end
                S_TICK_DIV: begin
                    if (r_mode == M_COLOR && r_bit == 6'd0 && r_byte != 2'd3) begin
                        r_acc[8*r_byte +: 8] <= ab + (r_neg
                            ? 8'(-(!trial[17] ? {r_num[6:0], 1'b1} : {r_num[6:0], 1'b0}))
                            : (!trial[17] ? {r_num[6:0], 1'b1} : {r_num[6:0], 1'b0}));
                        r_byte <= r_byte + 1'b1;
                        r_bit <= 6'd47;
                        r_rem <= '0;
                        r_num <= 48'(bmag_next * pp_hold);
                        r_neg <= db_next[9];
                    end else if (r_mode != M_FIXED) begin
                        if (!trial[17]) begin
                            r_rem <= trial[16:0];
                            r_num <= {r_num[46:0], 1'b1};
                        end else begin
                            r_rem <= {r_rem[15:0], r_num[47]};
                            r_num <= {r_num[46:0], 1'b0};
                        end
                        if (r_bit != 6'd0) begin
                            r_bit <= r_bit - 1'b1;
                        end
                    end
                end
                S_TICK_EMIT: begin
                    o_valid <= 1'b1;
                    o_out.status <= ST_OK;
                    o_out.out_target <= 8'(r_tg[i_ix]);
                    o_out.out_property <= r_pr[i_ix];
                    o_out.last <= (r_i + 1'b1 == r_count);
                    case (r_mode)
                        M_WORD: o_out.out_value <= r_a[i_ix] + q32;
                        M_COLOR: o_out.out_value <= {
                            ab + (r_neg ? 8'(-r_num[7:0]) : r_num[7:0]),
                            r_acc[23:0]};
                        default: o_out.out_value <= r_fixed;
                    endcase
                    r_pos[i_ix] <= pos_inc;
                    r_i <= r_i + 1'b1;
                    r_byte <= '0;
                end
                S_TICK_SWEEP: begin
                    if (r_i != r_count) begin
                        if (!(r_pos[i_ix] >= r_len[i_ix] && !r_rep[i_ix])) begin
                            r_tg[w_ix] <= r_tg[i_ix];
                            r_pr[w_ix] <= r_pr[i_ix];
                            r_col[w_ix] <= r_col[i_ix];
                            r_rep[w_ix] <= r_rep[i_ix];
                            r_a[w_ix] <= r_a[i_ix];
                            r_z[w_ix] <= r_z[i_ix];
                            r_pos[w_ix] <= (r_pos[i_ix] >= r_len[i_ix]) ? '0 : r_pos[i_ix];
                            r_len[w_ix] <= r_len[i_ix];
                            r_w <= r_w + 1'b1;
                        end
                        r_i <= r_i + 1'b1;
                    end else begin
                        r_count <= r_w;
                    end
                end
                S_FINISH: begin
                    if (r_count != '0) begin
                        o_valid <= 1'b1;
                        o_out.status <= ST_OK;
                        o_out.out_target <= 8'(r_tg[r_count[IDX_W-1:0] - 1'b1]);
                        o_out.out_property <= r_pr[r_count[IDX_W-1:0] - 1'b1];
                        o_out.out_value <= r_z[r_count[IDX_W-1:0] - 1'b1];
                        o_out.last <= (r_count == CNT_W'(1));
                        r_count <= r_count - 1'b1;
                    end
                end
                S_DETACH: begin
                    if (r_i != r_count) begin
                        if (r_tg[i_ix] != cmd_tg) begin
                            r_tg[w_ix] <= r_tg[i_ix];
                            r_pr[w_ix] <= r_pr[i_ix];
                            r_col[w_ix] <= r_col[i_ix];
                            r_rep[w_ix] <= r_rep[i_ix];
                            r_a[w_ix] <= r_a[i_ix];
                            r_z[w_ix] <= r_z[i_ix];
                            r_pos[w_ix] <= r_pos[i_ix];
                            r_len[w_ix] <= r_len[i_ix];
                            r_w <= r_w + 1'b1;
                        end
                        r_i <= r_i + 1'b1;
                    end else begin
                        r_count <= r_w;
                    end
                end
                default: ;
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(SLOTS)) else $error("entry count above table size");
    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy)) else $error("result while idle");
    a_start_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WRITE) |=> (o_valid && o_out.last)) else $error("start unanswered");
`endif
endmodule
`default_nettype wire
